@@ hdl/i2cm_pkg.sv @@
// Shared types, command codes and constants of the I2C master byte engine.
package i2cm_pkg;

  // Width of the phase length register.
  localparam int unsigned CfgWidth = 16;
  // Default width of the phase timer.
  localparam int unsigned TimerWidthDefault = 16;
  // Phase length after reset, in ticks.
  localparam logic [CfgWidth-1:0] PhaseTicksReset = 16'd10;
  // Number of bit phases before the acknowledge slot (8 bits of 3 phases).
  localparam logic [4:0] BitPhases = 5'd24;

  // Command codes, as carried in the request field.
  typedef enum logic [2:0] {
    CmdStart  = 3'd0,
    CmdRstart = 3'd1,
    CmdStop   = 3'd2,
    CmdWrite  = 3'd3,
    CmdRead   = 3'd4,
    CmdIdle   = 3'd7
  } cmd_e;

  // One input transaction: one tick of line timing.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       master_ack;
    logic       sda_in;
  } in_item_t;

  // One output transaction: line drives and status after the tick.
  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_ack;
  } out_item_t;

  // Input register contents handed to the sequencer.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

  // Number of timing phases of a command.
  function automatic logic [4:0] phase_count(cmd_e cmd);
    logic [4:0] cnt;
    case (cmd)
      CmdStart:  cnt = 5'd3;
      CmdStop:   cnt = 5'd3;
      CmdRstart: cnt = 5'd4;
      default:   cnt = 5'd27;
    endcase
    return cnt;
  endfunction

endpackage

@@ hdl/i2c_master_byte_engine_unit.sv @@
// Top level of the I2C master byte engine: input register, sequencer, output register.
//
//   Channel  Handshake              Payload       Meaning
//   in       in_valid_i/in_ready_o  in_item_i     one tick: command offer and SDA sample
//   out      out_valid_o/out_ready_i out_item_o   line drives and status after the tick
//   cfg      cfg_we_i               cfg_wdata_i   ticks per timing phase
//
// Each transaction passes the input register and then the output register; the
// sequencer update between them runs once for each transaction that moves on, so a
// new transaction can be accepted every cycle while the output is not stalled.
// Reset clears the sequencer to idle with both lines released and sets the phase
// length to 10 ticks. A stalled output holds the sequencer and the input register;
// in_ready_o stays high while out_ready_i is high.
module i2c_master_byte_engine_unit #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::TimerWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  i2cm_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output i2cm_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [i2cm_pkg::CfgWidth-1:0] cfg_wdata_i
);
  import i2cm_pkg::*;

  in_stage_t stage;
  out_item_t res;
  logic      load_ready;
  logic      advance;

  // The held transaction moves on when the output register can take its result.
  assign advance = stage.valid && load_ready;

  i2cm_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  i2cm_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stage_i     (stage),
    .advance_i   (advance),
    .res_o       (res)
  );

  i2cm_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (stage.valid),
    .load_ready_o (load_ready),
    .res_i        (res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ hdl/i2cm_in_reg.sv @@
// Input register stage of the I2C master byte engine.
module i2cm_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cm_pkg::in_item_t  in_item_i,
  input  logic                advance_i,
  output i2cm_pkg::in_stage_t stage_o
);
  import i2cm_pkg::*;

  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q;

  // The register takes a new transaction when empty or when its content moves on.
  assign in_ready_o = !in_valid_q || advance_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  // Valid flag under reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  assign stage_o.valid = in_valid_q;
  assign stage_o.item  = in_item_q;

endmodule

@@ hdl/i2cm_core.sv @@
// Phase sequencer of the I2C master byte engine: line state and one tick of update.
module i2cm_core #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::TimerWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cm_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  i2cm_pkg::in_stage_t           stage_i,
  input  logic                          advance_i,
  output i2cm_pkg::out_item_t           res_o
);
  import i2cm_pkg::*;

  // Compare width that holds both the timer and the phase length.
  localparam int unsigned CmpWidth = (TIMER_WIDTH > CfgWidth) ? TIMER_WIDTH : CfgWidth;

  // Line actions at the start of a phase.
  typedef enum logic [1:0] {
    ActKeep,
    ActLow,
    ActRel
  } act_e;

  logic [CfgWidth-1:0]    phase_ticks_q;
  cmd_e                   cmd_q, cmd_d;
  logic [4:0]             idx_q, idx_d, idx_n;
  logic [1:0]             sub_q, sub_d, sub_n;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d, timer_inc;
  logic [7:0]             sr_q, sr_d;
  logic                   ack_q, ack_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic [7:0]             rx_q, rx_d;
  logic                   seen_q, seen_d;
  logic                   done, enter;
  act_e                   sda_act, scl_act;
  in_item_t               it;

  assign it = stage_i.item;

  // Next state for one tick: timer and phase advance, command start, phase entry actions.
  always_comb begin
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    sub_d     = sub_q;
    timer_d   = timer_q;
    sr_d      = sr_q;
    ack_d     = ack_q;
    rx_d      = rx_q;
    seen_d    = seen_q;
    done      = 1'b0;
    enter     = 1'b0;
    sda_act   = ActKeep;
    scl_act   = ActKeep;
    timer_inc = timer_q + 1'b1;
    idx_n     = idx_q + 5'd1;
    sub_n     = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;

    if (cmd_q != CmdIdle) begin
      // A phase ends when the timer wraps or reaches the phase length.
      if (timer_inc == '0 ||
          CmpWidth'(timer_inc) >= CmpWidth'(phase_ticks_q)) begin
        timer_d = '0;
        if (idx_n >= phase_count(cmd_q)) begin
          if (cmd_q == CmdRead) begin
            rx_d = sr_q;
          end
          cmd_d = CmdIdle;
          idx_d = '0;
          sub_d = '0;
          done  = 1'b1;
        end else begin
          idx_d = idx_n;
          sub_d = sub_n;
          enter = 1'b1;
        end
      end else begin
        timer_d = timer_inc;
      end
    end else if (it.cmd_valid && it.req_type <= 3'(CmdRead)) begin
      cmd_d   = cmd_e'(it.req_type);
      idx_d   = '0;
      sub_d   = '0;
      timer_d = '0;
      sr_d    = (it.req_type == 3'(CmdWrite)) ? it.tx_byte : 8'd0;
      ack_d   = it.master_ack;
      enter   = 1'b1;
    end

    // Actions taken as the new phase begins.
    if (enter) begin
      case (cmd_d)
        CmdStart: begin
          if (idx_d == 5'd0) begin
            sda_act = ActRel;
            scl_act = ActRel;
          end else if (idx_d == 5'd1) begin
            sda_act = ActLow;
          end else begin
            scl_act = ActLow;
          end
        end
        CmdRstart: begin
          if (idx_d == 5'd0) begin
            sda_act = ActRel;
          end else if (idx_d == 5'd1) begin
            scl_act = ActRel;
          end else if (idx_d == 5'd2) begin
            sda_act = ActLow;
          end else begin
            scl_act = ActLow;
          end
        end
        CmdStop: begin
          if (idx_d == 5'd0) begin
            sda_act = ActLow;
          end else if (idx_d == 5'd1) begin
            scl_act = ActRel;
          end else begin
            sda_act = ActRel;
          end
        end
        CmdWrite: begin
          if (idx_d < BitPhases) begin
            if (sub_d == 2'd0) begin
              sda_act = sr_d[7] ? ActRel : ActLow;
            end else if (sub_d == 2'd1) begin
              scl_act = ActRel;
            end else begin
              scl_act = ActLow;
              sr_d    = {sr_d[6:0], 1'b0};
            end
          end else begin
            if (sub_d == 2'd0) begin
              sda_act = ActRel;
            end else if (sub_d == 2'd1) begin
              scl_act = ActRel;
            end else begin
              // The slave acknowledges by holding SDA low at the end of SCL high.
              seen_d  = ~it.sda_in;
              scl_act = ActLow;
            end
          end
        end
        CmdRead: begin
          if (idx_d < BitPhases) begin
            if (sub_d == 2'd0) begin
              sda_act = ActRel;
            end else if (sub_d == 2'd1) begin
              scl_act = ActRel;
            end else begin
              sr_d    = {sr_d[6:0], it.sda_in};
              scl_act = ActLow;
            end
          end else begin
            if (sub_d == 2'd0) begin
              sda_act = ack_d ? ActLow : ActRel;
            end else if (sub_d == 2'd1) begin
              scl_act = ActRel;
            end else begin
              scl_act = ActLow;
            end
          end
        end
        default: begin
          sda_act = ActKeep;
          scl_act = ActKeep;
        end
      endcase
    end

    // Open-drain line drives keep their value unless an action names them.
    case (sda_act)
      ActLow:  sda_d = 1'b1;
      ActRel:  sda_d = 1'b0;
      default: sda_d = sda_q;
    endcase
    case (scl_act)
      ActLow:  scl_d = 1'b1;
      ActRel:  scl_d = 1'b0;
      default: scl_d = scl_q;
    endcase
  end

  // Phase length register, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  // Sequencer state, updated once for each transaction that moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CmdIdle;
      idx_q   <= '0;
      sub_q   <= '0;
      timer_q <= '0;
      sr_q    <= '0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b0;
      sda_q   <= 1'b0;
      rx_q    <= '0;
      seen_q  <= 1'b0;
    end else if (advance_i) begin
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      timer_q <= timer_d;
      sr_q    <= sr_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rx_q    <= rx_d;
      seen_q  <= seen_d;
    end
  end

  // Result of this tick, taken by the output register.
  assign res_o.scl_drive_low = scl_d;
  assign res_o.sda_drive_low = sda_d;
  assign res_o.busy_res      = (cmd_d != CmdIdle);
  assign res_o.done_res      = done;
  assign res_o.rx_byte       = rx_d;
  assign res_o.slave_ack     = seen_d;

endmodule

@@ hdl/i2cm_out_reg.sv @@
// Output register stage of the I2C master byte engine.
module i2cm_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  output logic                load_ready_o,
  input  i2cm_pkg::out_item_t res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cm_pkg::out_item_t out_item_o
);
  import i2cm_pkg::*;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // A new result may enter when the register is empty or is being read this cycle.
  assign load_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_ready_o) begin
      out_valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_i) begin
      out_item_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hdl/i2cm_checker.sv @@
// Port-level checks of the I2C master byte engine, bound to the top level.
module i2cm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input i2cm_pkg::out_item_t out_item_o
);
  import i2cm_pkg::*;

  // A stalled result transaction keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output transaction changed while stalled");

  // A completed sequence leaves the engine idle on the same tick.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done reported while still busy");

  // With the output side ready the input side never stalls.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // Done is a single-tick pulse: two done results cannot follow back to back.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.done_res ##1 out_valid_o
      |-> !out_item_o.done_res)
    else $error("done pulse longer than one tick");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (.*);

@@ sim/i2c_master_byte_engine_unit_tb.sv @@
// Self-checking testbench for the I2C master byte engine: directed and random tick streams.
`timescale 1ns / 100ps

module i2c_master_byte_engine_unit_tb;
  import i2cm_pkg::*;

  // SDA sources for a stream of ticks.
  localparam int SdaLow = 0;
  localparam int SdaHigh = 1;
  localparam int SdaRandom = 2;

  // Phase counts of the command sequences.
  localparam logic [4:0] ShortPhases = 5'd3;
  localparam logic [4:0] RstartPhases = 5'd4;
  localparam logic [4:0] BytePhases = 5'd27;

  // Longest phase length that the register holds.
  localparam logic [CfgWidth-1:0] PhaseTicksMax = 16'hFFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgWidth-1:0] cfg_wdata_i = '0;

  // Idle rates of both sides, in percent per cycle.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatch_count = 0;

  // Expected output transactions, oldest first.
  out_item_t tick_results_q[$];

  // Predicted sequencer state.
  logic [CfgWidth-1:0] cfg_phase_ticks;
  cmd_e                seq_cmd;
  logic [4:0]          seq_phase;
  logic [15:0]         seq_timer;
  logic [7:0]          seq_shift;
  logic                seq_ack_req;
  logic                scl_low;
  logic                sda_low;
  logic [7:0]          rx_hold;
  logic                ack_hold;

  i2c_master_byte_engine_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Line actions that take effect as phase p of the running command begins.
  task automatic begin_phase(input logic [4:0] p, input logic sda_in);
    logic [4:0] sub;
    sub = p % 5'd3;
    case (seq_cmd)
      CmdStart: begin
        if (p == 5'd0) begin
          sda_low = 1'b0;
          scl_low = 1'b0;
        end else if (p == 5'd1) begin
          sda_low = 1'b1;
        end else begin
          scl_low = 1'b1;
        end
      end
      CmdRstart: begin
        if (p == 5'd0) sda_low = 1'b0;
        else if (p == 5'd1) scl_low = 1'b0;
        else if (p == 5'd2) sda_low = 1'b1;
        else scl_low = 1'b1;
      end
      CmdStop: begin
        if (p == 5'd0) sda_low = 1'b1;
        else if (p == 5'd1) scl_low = 1'b0;
        else sda_low = 1'b0;
      end
      CmdWrite: begin
        if (p < BitPhases) begin
          if (sub == 5'd0) begin
            sda_low = ~seq_shift[7];
          end else if (sub == 5'd1) begin
            scl_low = 1'b0;
          end else begin
            scl_low = 1'b1;
            seq_shift = {seq_shift[6:0], 1'b0};
          end
        end else begin
          if (sub == 5'd0) begin
            sda_low = 1'b0;
          end else if (sub == 5'd1) begin
            scl_low = 1'b0;
          end else begin
            // The slave acknowledges by holding SDA low at the end of SCL high.
            ack_hold = ~sda_in;
            scl_low = 1'b1;
          end
        end
      end
      CmdRead: begin
        if (p < BitPhases) begin
          if (sub == 5'd0) begin
            sda_low = 1'b0;
          end else if (sub == 5'd1) begin
            scl_low = 1'b0;
          end else begin
            seq_shift = {seq_shift[6:0], sda_in};
            scl_low = 1'b1;
          end
        end else begin
          if (sub == 5'd0) sda_low = seq_ack_req;
          else if (sub == 5'd1) scl_low = 1'b0;
          else scl_low = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Advance the predicted sequencer by one tick and form the expected output.
  task automatic step_sequencer(input in_item_t it, output out_item_t res);
    logic [16:0] span;
    logic [15:0] tnext;
    logic [4:0]  last;
    logic        done;
    done = 1'b0;
    span = (cfg_phase_ticks == '0) ? 17'd1 : {1'b0, cfg_phase_ticks};
    if (seq_cmd != CmdIdle) begin
      tnext = seq_timer + 16'd1;
      seq_timer = tnext;
      if (tnext == 16'd0 || {1'b0, tnext} >= span) begin
        seq_timer = '0;
        seq_phase = seq_phase + 5'd1;
        if (seq_cmd == CmdStart || seq_cmd == CmdStop) last = ShortPhases;
        else if (seq_cmd == CmdRstart) last = RstartPhases;
        else last = BytePhases;
        if (seq_phase >= last) begin
          if (seq_cmd == CmdRead) rx_hold = seq_shift;
          seq_cmd = CmdIdle;
          seq_phase = '0;
          done = 1'b1;
        end else begin
          begin_phase(seq_phase, it.sda_in);
        end
      end
    end else if (it.cmd_valid && it.req_type <= CmdRead) begin
      // A new command is taken only when idle at the start of the tick.
      seq_cmd = cmd_e'(it.req_type);
      seq_phase = '0;
      seq_timer = '0;
      seq_shift = (it.req_type == CmdWrite) ? it.tx_byte : 8'h00;
      seq_ack_req = it.master_ack;
      begin_phase(5'd0, it.sda_in);
    end
    res.scl_drive_low = scl_low;
    res.sda_drive_low = sda_low;
    res.busy_res = (seq_cmd != CmdIdle);
    res.done_res = done;
    res.rx_byte = rx_hold;
    res.slave_ack = ack_hold;
  endtask

  // Offer one tick transaction and record its prediction once accepted.
  // Called at a rising edge; returns at the edge of acceptance.
  task automatic send_tick(input in_item_t it);
    out_item_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    step_sequencer(it, res);
    tick_results_q.push_back(res);
  endtask

  // A random tick that offers some command, so offers while busy are exercised.
  function automatic in_item_t busy_tick(input int sda_mode);
    in_item_t it;
    it.cmd_valid = 1'b1;
    it.req_type = 3'($urandom_range(7));
    it.tx_byte = 8'($urandom);
    it.master_ack = 1'($urandom);
    if (sda_mode == SdaLow) it.sda_in = 1'b0;
    else if (sda_mode == SdaHigh) it.sda_in = 1'b1;
    else it.sda_in = 1'($urandom);
    return it;
  endfunction

  // Issue one command, then keep ticking until the sequence has finished.
  task automatic run_cmd(input logic [2:0] req, input logic [7:0] tx, input logic ack,
                         input int sda_mode);
    in_item_t it;
    it = busy_tick(sda_mode);
    it.req_type = req;
    it.tx_byte = tx;
    it.master_ack = ack;
    send_tick(it);
    while (seq_cmd != CmdIdle) send_tick(busy_tick(sda_mode));
  endtask

  // Stop offering and wait until every expected transaction has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the phase length register; the pipeline must be empty.
  task automatic write_phase_ticks(input logic [CfgWidth-1:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_phase_ticks = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // Reset phase length of 10 ticks, and ticks with no command offered.
  task automatic test_reset_length();
    in_item_t it;
    it = busy_tick(SdaRandom);
    it.cmd_valid = 1'b0;
    it.req_type = CmdStart;
    send_tick(it);
    run_cmd(CmdStart, 8'h00, 1'b0, SdaRandom);
  endtask

  // Start, repeated start and stop at the shortest phase.
  task automatic test_bus_conditions();
    write_phase_ticks(16'd1);
    run_cmd(CmdStart, 8'h00, 1'b0, SdaRandom);
    run_cmd(CmdRstart, 8'hFF, 1'b1, SdaRandom);
    run_cmd(CmdStop, 8'h00, 1'b0, SdaRandom);
  endtask

  // Write bytes with all ones and NACK, all zeros and ACK, and random content.
  task automatic test_write_byte();
    run_cmd(CmdWrite, 8'hFF, 1'b0, SdaHigh);
    run_cmd(CmdWrite, 8'h00, 1'b1, SdaLow);
    run_cmd(CmdWrite, 8'($urandom), 1'($urandom), SdaRandom);
  endtask

  // Read bytes of all ones with NACK, all zeros with ACK, and random data.
  task automatic test_read_byte();
    run_cmd(CmdRead, 8'hFF, 1'b0, SdaHigh);
    run_cmd(CmdRead, 8'h00, 1'b1, SdaLow);
    run_cmd(CmdRead, 8'($urandom), 1'($urandom), SdaRandom);
  endtask

  // Unknown request codes leave the block idle.
  task automatic test_unknown_request();
    in_item_t it;
    for (int code = 5; code <= 7; code++) begin
      it = busy_tick(SdaRandom);
      it.req_type = 3'(code);
      send_tick(it);
    end
  endtask

  // A phase length of zero behaves as one tick.
  task automatic test_zero_length();
    write_phase_ticks(16'd0);
    run_cmd(CmdWrite, 8'($urandom), 1'b1, SdaRandom);
    run_cmd(CmdStop, 8'h00, 1'b0, SdaRandom);
  endtask

  // Longest phase, shortened by a register write while the command runs.
  task automatic test_length_change_midphase();
    in_item_t it;
    write_phase_ticks(PhaseTicksMax);
    it = busy_tick(SdaRandom);
    it.req_type = CmdWrite;
    send_tick(it);
    repeat (40) send_tick(busy_tick(SdaRandom));
    write_phase_ticks(16'd2);
    while (seq_cmd != CmdIdle) send_tick(busy_tick(SdaRandom));
  endtask

  // Random tick streams over several phase lengths and idling patterns.
  task automatic test_random_traffic();
    logic [CfgWidth-1:0] lengths [8] = '{16'd1, 16'd2, 16'd3, 16'd0, 16'd1, 16'd4, 16'd2, 16'd1};
    in_item_t it;
    for (int seg = 0; seg < 8; seg++) begin
      write_phase_ticks(lengths[seg]);
      case (seg % 4)
        0: set_idling(0, 0);
        1: set_idling(54, 0);
        2: set_idling(0, 54);
        default: set_idling(29, 29);
      endcase
      repeat (82) begin
        it = busy_tick(SdaRandom);
        it.cmd_valid = ($urandom_range(3) != 0);
        // Mostly defined commands, with some unknown codes mixed in.
        if ($urandom_range(7) == 0) it.req_type = 3'($urandom_range(7, 5));
        else it.req_type = 3'($urandom_range(4));
        send_tick(it);
      end
    end
  endtask

  // Compare one field of a result transaction.
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin : rx_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tick_results_q.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, out_item_o);
        mismatch_count++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("scl_drive_low", 8'(want.scl_drive_low), 8'(out_item_o.scl_drive_low));
        check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(out_item_o.sda_drive_low));
        check_field("busy_res", 8'(want.busy_res), 8'(out_item_o.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_item_o.done_res));
        check_field("rx_byte", want.rx_byte, out_item_o.rx_byte);
        check_field("slave_ack", 8'(want.slave_ack), 8'(out_item_o.slave_ack));
      end
    end
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Test sequence.
  initial begin
    cfg_phase_ticks = PhaseTicksReset;
    seq_cmd = CmdIdle;
    seq_phase = '0;
    seq_timer = '0;
    seq_shift = '0;
    seq_ack_req = 1'b0;
    scl_low = 1'b0;
    sda_low = 1'b0;
    rx_hold = '0;
    ack_hold = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_length();
    test_bus_conditions();
    test_write_byte();
    test_read_byte();
    test_unknown_request();
    test_zero_length();
    test_length_change_midphase();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
